// ----- rtl/core/gaussian_kl_divergence_core_macros.svh -----
// ----------------------------------------------------------------------------
// gaussian_kl_divergence_core_macros
// assertion macros shared by the gaussian kl divergence rtl
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_KL_DIVERGENCE_CORE_MACROS_SVH
`define GAUSSIAN_KL_DIVERGENCE_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define GKL_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gkl assertion failed");

// next-cycle implication, disabled while in reset
`define GKL_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gkl assertion failed");

`endif

// ----- rtl/core/gkl_pkg.sv -----
// ----------------------------------------------------------------------------
// gkl_pkg
// types and constants of the gaussian kl divergence core
// ----------------------------------------------------------------------------
package gkl_pkg;

    localparam int IN_WIDTH  = 16;
    localparam int OUT_WIDTH = 32;
    localparam int LOG_FRAC  = 24;
    localparam int OUT_FRAC  = 16;
    localparam int LN_SHIFT  = 40;
    localparam int HALF_Q16  = 32768;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // output queue occupancy
    localparam logic [1:0] FIFO_EMPTY = 2'd0;
    localparam logic [1:0] FIFO_FULL  = 2'd2;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] mean_p;
        logic        [IN_WIDTH-1:0] sigma_p;
        logic signed [IN_WIDTH-1:0] mean_q;
        logic        [IN_WIDTH-1:0] sigma_q;
    } gkl_in_t;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] divergence;
        logic                 invalid;
    } gkl_out_t;

endpackage

// ----- rtl/core/gkl_delay.sv -----
// ----------------------------------------------------------------------------
// gkl_delay
// enable-gated shift line that aligns side results with the divider
// ----------------------------------------------------------------------------
module gkl_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             ce,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] dly_reg [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            dly_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign dout = dly_reg[DEPTH-1];

endmodule

// ----- rtl/core/gkl_log2.sv -----
// ----------------------------------------------------------------------------
// gkl_log2
// pipelined log2: leading-one normalize, then one mantissa squaring per stage
// ----------------------------------------------------------------------------
module gkl_log2 #(
    parameter int IN_W   = gkl_pkg::IN_WIDTH,
    parameter int FRAC_W = gkl_pkg::LOG_FRAC,
    localparam int MSB_W = $clog2(IN_W)
) (
    input  logic                    aclk,
    input  logic                    ce,
    input  logic [IN_W-1:0]         x,
    output logic [MSB_W+FRAC_W-1:0] log_val
);

    // mantissa is q1.30
    localparam int Y_FRAC = 30;
    localparam int Y_W    = Y_FRAC + 1;
    localparam int EXT_W  = IN_W + Y_W;

    logic [MSB_W-1:0]  msb;
    logic [EXT_W-1:0]  ext;
    logic [Y_W-1:0]    y_first;

    logic [Y_W-1:0]    y_reg    [0:FRAC_W];
    logic [MSB_W-1:0]  msb_reg  [0:FRAC_W];
    logic [FRAC_W-1:0] frac_reg [0:FRAC_W];

    // leading one
    always_comb begin
        msb = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (x[i]) begin
                msb = MSB_W'(i);
            end
        end
    end

    // place the leading one at bit 30
    assign ext     = {x, {Y_W{1'b0}}} >> ({1'b0, msb} + (MSB_W+1)'(1));
    assign y_first = ext[Y_W-1:0];

    always_ff @(posedge aclk) begin
        if (ce) begin
            y_reg[0]    <= y_first;
            msb_reg[0]  <= msb;
            frac_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < FRAC_W; k++) begin : g_step
        logic [2*Y_W-1:0] sq;
        logic [Y_W:0]     p;
        logic [Y_W-1:0]   y_next;
        logic [FRAC_W-1:0] frac_next;

        always_comb begin
            sq        = y_reg[k] * y_reg[k];
            p         = sq[Y_FRAC+Y_W:Y_FRAC];
            y_next    = p[Y_W] ? p[Y_W:1] : p[Y_W-1:0];
            frac_next = {frac_reg[k][FRAC_W-2:0], p[Y_W]};
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                y_reg[k+1]    <= y_next;
                msb_reg[k+1]  <= msb_reg[k];
                frac_reg[k+1] <= frac_next;
            end
        end
    end

    assign log_val = {msb_reg[FRAC_W], frac_reg[FRAC_W]};

endmodule

// ----- rtl/core/gkl_divider.sv -----
// ----------------------------------------------------------------------------
// gkl_divider
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module gkl_divider #(
    parameter int NUM_W = 2 * gkl_pkg::IN_WIDTH + 1 + gkl_pkg::OUT_FRAC,
    parameter int DEN_W = 2 * gkl_pkg::IN_WIDTH + 1
) (
    input  logic             aclk,
    input  logic             ce,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [0:NUM_W];
    logic [NUM_W-1:0] nq_reg  [0:NUM_W];   // numerator bits shift out, quotient in
    logic [DEN_W-1:0] den_reg [0:NUM_W];

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0] <= '0;
            nq_reg[0]  <= num;
            den_reg[0] <= den;
        end
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W:0]   r2;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] nq_next;

        always_comb begin
            r2       = {rem_reg[k], nq_reg[k][NUM_W-1]};
            diff     = r2 - {1'b0, den_reg[k]};
            ge       = (r2 >= {1'b0, den_reg[k]});
            rem_next = ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
            nq_next  = {nq_reg[k][NUM_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k+1] <= rem_next;
                nq_reg[k+1]  <= nq_next;
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    assign quo = nq_reg[NUM_W];

endmodule

// ----- rtl/core/gaussian_kl_divergence_core.sv -----
// throughput: one word per cycle, except while the output queue is full;
// the whole pipeline advances together
// depth is set by the restoring divider, one quotient bit per stage
// a two-word output queue lets the pipeline keep accepting while a result waits
// reset: aresetn synchronous active low, clears valid bits and queue count only
// ----------------------------------------------------------------------------
// gaussian_kl_divergence_core
// kl(p||q) of two univariate normals, q12.4 in, unsigned q16.16 out
// ----------------------------------------------------------------------------
`include "gaussian_kl_divergence_core_macros.svh"

module gaussian_kl_divergence_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gkl_pkg::gkl_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output gkl_pkg::gkl_out_t m_data
);

    localparam int W       = gkl_pkg::IN_WIDTH;
    localparam int OW      = gkl_pkg::OUT_WIDTH;
    localparam int SQ_W    = 2 * W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int NUM_W   = SUM_W + gkl_pkg::OUT_FRAC;
    localparam int DEN_W   = SQ_W + 1;
    localparam int MSB_W   = $clog2(W);
    localparam int LOGW    = MSB_W + gkl_pkg::LOG_FRAC;
    localparam int PROD_W  = LOGW + 32;
    localparam int LNW     = PROD_W + 1 - gkl_pkg::LN_SHIFT;
    localparam int ADJW    = LNW + 2;
    localparam int QX      = (NUM_W > 64) ? NUM_W : 65;
    localparam int SUMX_W  = 66;
    // stage at which the quotient is ready (input register is stage 1)
    localparam int QT      = 3 + NUM_W;
    // stage at which the log term is ready
    localparam int LOG_DONE = 5 + gkl_pkg::LOG_FRAC;
    localparam int ADJ_DLY  = QT - LOG_DONE;
    localparam logic [SUMX_W-1:0] OMAX = (SUMX_W'(1) << OW) - SUMX_W'(1);
    localparam logic [PROD_W:0]   ROUND = (PROD_W+1)'(1) << (gkl_pkg::LN_SHIFT - 1);

    // pipeline control
    logic          ce;
    logic [QT:0]   vld_reg;
    logic [QT:0]   vld_next;

    // stage 1: input word
    logic             zero_sigma;
    gkl_pkg::gkl_in_t in_reg;
    logic             inv_reg;

    // stage 2: squares
    logic [W:0]      dd;
    logic [W:0]      dneg;
    logic [W-1:0]    dmag;
    logic [SQ_W-1:0] sp2_reg;
    logic [SQ_W-1:0] d2_reg;
    logic [SQ_W-1:0] sq2_reg;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [NUM_W-1:0] quo;

    // log side
    logic [LOGW-1:0]  log_p;
    logic [LOGW-1:0]  log_q;
    logic [LOGW:0]    dl;
    logic [LOGW:0]    dl_neg;
    logic [LOGW-1:0]  lmag_reg;
    logic             lneg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic             pneg_reg;
    logic [PROD_W:0]  rnd;
    logic [LNW-1:0]   lnmag;
    logic [ADJW-1:0]  adj_next;
    logic [ADJW-1:0]  adj_reg;
    logic [ADJW-1:0]  adj_al;
    logic             inv_al;

    // final combine
    logic [QX-1:0]     qx;
    logic              q_hi;
    logic [SUMX_W-1:0] sumv;
    logic [OW-1:0]     div_val;
    gkl_pkg::gkl_out_t res_next;
    gkl_pkg::gkl_out_t res_reg;

    // output queue
    logic              push;
    logic              pop;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    gkl_pkg::gkl_out_t buf0_reg;
    gkl_pkg::gkl_out_t buf0_next;
    gkl_pkg::gkl_out_t buf1_reg;
    gkl_pkg::gkl_out_t buf1_next;

    // stall only when the output queue is full
    assign ce      = (cnt_reg != gkl_pkg::FIFO_FULL);
    assign s_ready = ce;

    // valid bits march with the data
    always_comb begin
        vld_next = vld_reg;
        if (ce) begin
            vld_next = {vld_reg[QT-1:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: register the input word, flag zero sigma
    assign zero_sigma = (s_data.sigma_p == '0) || (s_data.sigma_q == '0);

    always_ff @(posedge aclk) begin
        if (ce) begin
            in_reg  <= s_data;
            inv_reg <= zero_sigma;
        end
    end

    // stage 2: mean difference and the three squares
    always_comb begin
        dd   = {in_reg.mean_p[W-1], in_reg.mean_p} - {in_reg.mean_q[W-1], in_reg.mean_q};
        dneg = -dd;
        // |mp - mq| never exceeds 2^W - 1
        dmag = dd[W] ? dneg[W-1:0] : dd[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sp2_reg <= in_reg.sigma_p * in_reg.sigma_p;
            d2_reg  <= dmag * dmag;
            sq2_reg <= in_reg.sigma_q * in_reg.sigma_q;
        end
    end

    // quadratic term: (sp^2 + d^2) * 2^16 / (2 sq^2), q4 scales cancel
    assign div_num = {SUM_W'(sp2_reg) + SUM_W'(d2_reg), {gkl_pkg::OUT_FRAC{1'b0}}};
    assign div_den = {sq2_reg, 1'b0};

    gkl_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk (aclk),
        .ce   (ce),
        .num  (div_num),
        .den  (div_den),
        .quo  (quo)
    );

    // log term: log2 of each sigma in parallel
    gkl_log2 #(
        .IN_W   (W),
        .FRAC_W (gkl_pkg::LOG_FRAC)
    ) u_log_p (
        .aclk    (aclk),
        .ce      (ce),
        .x       (in_reg.sigma_p),
        .log_val (log_p)
    );

    gkl_log2 #(
        .IN_W   (W),
        .FRAC_W (gkl_pkg::LOG_FRAC)
    ) u_log_q (
        .aclk    (aclk),
        .ce      (ce),
        .x       (in_reg.sigma_q),
        .log_val (log_q)
    );

    // difference of the logs as sign and magnitude
    always_comb begin
        dl     = {1'b0, log_q} - {1'b0, log_p};
        dl_neg = -dl;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            lneg_reg <= dl[LOGW];
            lmag_reg <= dl[LOGW] ? dl_neg[LOGW-1:0] : dl[LOGW-1:0];
        end
    end

    // scale by ln2
    always_ff @(posedge aclk) begin
        if (ce) begin
            pneg_reg <= lneg_reg;
            prod_reg <= PROD_W'(lmag_reg) * PROD_W'(gkl_pkg::LN2_Q32);
        end
    end

    // round magnitude half up to q16, reapply sign, take off one half
    always_comb begin
        rnd      = (PROD_W+1)'(prod_reg) + ROUND;
        lnmag    = rnd[PROD_W:gkl_pkg::LN_SHIFT];
        adj_next = (pneg_reg ? -ADJW'(lnmag) : ADJW'(lnmag)) - ADJW'(gkl_pkg::HALF_Q16);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            adj_reg <= adj_next;
        end
    end

    // line up the log term and the invalid flag with the quotient
    gkl_delay #(
        .WIDTH (ADJW),
        .DEPTH (ADJ_DLY)
    ) u_adj_dly (
        .aclk (aclk),
        .ce   (ce),
        .din  (adj_reg),
        .dout (adj_al)
    );

    gkl_delay #(
        .WIDTH (1),
        .DEPTH (QT - 1)
    ) u_inv_dly (
        .aclk (aclk),
        .ce   (ce),
        .din  (inv_reg),
        .dout (inv_al)
    );

    // final stage: sum, clamp at zero, saturate at the top
    always_comb begin
        qx   = QX'(quo);
        q_hi = |qx[QX-1:64];
        sumv = {2'b00, qx[63:0]} + SUMX_W'($signed(adj_al));
        if (q_hi) begin
            div_val = OMAX[OW-1:0];
        end else if (sumv[SUMX_W-1]) begin
            div_val = '0;
        end else if (sumv > OMAX) begin
            div_val = OMAX[OW-1:0];
        end else begin
            div_val = sumv[OW-1:0];
        end
        res_next.divergence = inv_al ? '0 : div_val;
        res_next.invalid    = inv_al;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            res_reg <= res_next;
        end
    end

    // two-word output queue, head in buf0
    always_comb begin
        push      = ce && vld_reg[QT];
        pop       = (cnt_reg != gkl_pkg::FIFO_EMPTY) && m_ready;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
        buf0_next = buf0_reg;
        buf1_next = buf1_reg;
        if (pop) begin
            if (cnt_reg == gkl_pkg::FIFO_FULL) begin
                buf0_next = buf1_reg;
            end else if (push) begin
                buf0_next = res_reg;
            end
        end else if (push) begin
            if (cnt_reg == gkl_pkg::FIFO_EMPTY) begin
                buf0_next = res_reg;
            end else begin
                buf1_next = res_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= gkl_pkg::FIFO_EMPTY;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
    end

    assign m_valid = (cnt_reg != gkl_pkg::FIFO_EMPTY);
    assign m_data  = buf0_reg;

    // an accepted word always occupies the first stage
    `GKL_ASSERT_NXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, vld_reg[0])
    // zero sigma is flagged in the input stage
    `GKL_ASSERT_NXT(a_zero_sigma_flag, aclk, aresetn, s_valid && s_ready && zero_sigma, inv_reg)
    // a finished word stays in the last stage while the queue is full
    `GKL_ASSERT_NXT(a_last_held, aclk, aresetn, vld_reg[QT] && !ce, vld_reg[QT])
    // invalid results carry zero divergence
    `GKL_ASSERT_IMP(a_invalid_zero, aclk, aresetn, m_valid && m_data.invalid, m_data.divergence == '0)

endmodule
